// File: sv/mbt_pkg.sv
// ============================================================================
// mbt_pkg
// Shared types and constants of the metaball band test.
// ============================================================================
package mbt_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SCALE_W  = 24;
    localparam int CENTER_W = 16;
    localparam int PROD_W   = SAMPLE_W + SCALE_W;
    localparam int TERM_W   = 15;
    localparam int POT_W    = 17;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam longint TERM_NUMER = 64'd419430400;  // 100 * 2^22
    localparam longint ONE_Q14    = 64'd16384;
    localparam longint TERM_SCALE = 64'd100;
    localparam int     BAND_LOW   = 28160;           // 110 in Q9.8
    localparam int     BAND_HIGH  = 30720;           // 120 in Q9.8
    localparam int     POT_MAX    = 76800;           // three full terms

    localparam logic [2:0] REG_CENTER0_X = 3'd0;
    localparam logic [2:0] REG_CENTER0_Y = 3'd1;
    localparam logic [2:0] REG_CENTER1_X = 3'd2;
    localparam logic [2:0] REG_CENTER1_Y = 3'd3;
    localparam logic [2:0] REG_CENTER2_X = 3'd4;
    localparam logic [2:0] REG_CENTER2_Y = 3'd5;
    localparam logic [2:0] REG_X_SCALE   = 3'd6;
    localparam logic [2:0] REG_Y_SCALE   = 3'd7;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_x;
        logic [SAMPLE_W-1:0] sample_y;
    } point_t;

    typedef struct packed {
        logic             inside_res;
        logic [POT_W-1:0] potential;
    } result_t;

endpackage

// File: sv/metaball_band_test.sv
// ============================================================================
// metaball_band_test
// Metaball potential of a sample point against three centers, band flag.
// ============================================================================
// Takes one item per cycle while the output is not stalled and returns one
// result item per input item, in order. The depth of the pipeline is set by
// the square root pipeline, one root bit per stage, followed by a
// fifteen-stage divider for each center term.
// The whole pipeline advances together; when the output register holds an
// item that has not been taken, every stage holds and no item is accepted.
// The user must write registers over the APB-style port only while the block is idle; the block does not enforce it.
module metaball_band_test
    import mbt_pkg::*;
#(
    parameter int PIXEL_COORD_BITS = 12
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  point_t            in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output result_t           out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // Scaling shift: sample fraction bits plus ten.
    localparam int SHIFT = 26 - PIXEL_COORD_BITS;
    localparam int M_W   = PROD_W - SHIFT;
    localparam int K     = M_W + 2;
    localparam int C_LAT = K + 20;
    localparam int LAT   = C_LAT + 3;

    logic signed [CENTER_W-1:0] cx_reg [3];
    logic signed [CENTER_W-1:0] cy_reg [3];
    logic [SCALE_W-1:0]         x_scale_reg, y_scale_reg;

    logic [2:0]        reg_index;
    logic              cfg_write;
    logic              en;
    logic [LAT-1:0]    valid_reg;
    logic [PROD_W-1:0] px_reg, py_reg;
    logic [PROD_W-1:0] px_round, py_round;
    logic [M_W-1:0]    mx_reg, my_reg;
    logic [TERM_W-1:0] term [3];
    logic [POT_W-1:0]  pot_sum;
    result_t           out_reg;

    // ---- configuration registers ----
    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cx_reg[i] <= 16'sd8192;
                cy_reg[i] <= 16'sd8192;
            end
            x_scale_reg <= 24'd16384;
            y_scale_reg <= 24'd16384;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_CENTER0_X: cx_reg[0]   <= pwdata[CENTER_W-1:0];
                REG_CENTER0_Y: cy_reg[0]   <= pwdata[CENTER_W-1:0];
                REG_CENTER1_X: cx_reg[1]   <= pwdata[CENTER_W-1:0];
                REG_CENTER1_Y: cy_reg[1]   <= pwdata[CENTER_W-1:0];
                REG_CENTER2_X: cx_reg[2]   <= pwdata[CENTER_W-1:0];
                REG_CENTER2_Y: cy_reg[2]   <= pwdata[CENTER_W-1:0];
                REG_X_SCALE:   x_scale_reg <= pwdata[SCALE_W-1:0];
                REG_Y_SCALE:   y_scale_reg <= pwdata[SCALE_W-1:0];
                default:       ;
            endcase
        end
    end

    // Read back; centers read as their raw 16 bits.
    always_comb
    begin
        unique case (reg_index)
            REG_CENTER0_X: prdata = DATA_W'(unsigned'(cx_reg[0]));
            REG_CENTER0_Y: prdata = DATA_W'(unsigned'(cy_reg[0]));
            REG_CENTER1_X: prdata = DATA_W'(unsigned'(cx_reg[1]));
            REG_CENTER1_Y: prdata = DATA_W'(unsigned'(cy_reg[1]));
            REG_CENTER2_X: prdata = DATA_W'(unsigned'(cx_reg[2]));
            REG_CENTER2_Y: prdata = DATA_W'(unsigned'(cy_reg[2]));
            REG_X_SCALE:   prdata = DATA_W'(x_scale_reg);
            REG_Y_SCALE:   prdata = DATA_W'(y_scale_reg);
            default:       prdata = '0;
        endcase
    end

    // ---- pipeline control ----
    // Advance everything unless a finished item waits at the output.
    assign en        = !valid_reg[LAT-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = valid_reg[LAT-1];
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[LAT-2:0], in_valid};
    end

    // ---- scale to normalized space ----
    assign px_round = px_reg + (PROD_W'(1) << (SHIFT - 1));
    assign py_round = py_reg + (PROD_W'(1) << (SHIFT - 1));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= PROD_W'(in_data.sample_x) * PROD_W'(x_scale_reg);
            py_reg <= PROD_W'(in_data.sample_y) * PROD_W'(y_scale_reg);
            mx_reg <= px_round[PROD_W-1:SHIFT];
            my_reg <= py_round[PROD_W-1:SHIFT];
        end
    end

    // ---- one term per center ----
    for (genvar c = 0; c < 3; c++) begin : g_center
        mbt_center #(.M_W(M_W)) u_center
        (
            .clk  (clk),
            .en   (en),
            .mx   (mx_reg),
            .my   (my_reg),
            .cx   (cx_reg[c]),
            .cy   (cy_reg[c]),
            .term (term[c])
        );
    end

    // ---- sum and band check ----
    assign pot_sum = POT_W'(term[0]) + POT_W'(term[1]) + POT_W'(term[2]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.potential  <= pot_sum;
            out_reg.inside_res <= (pot_sum > POT_W'(BAND_LOW))
                               && (pot_sum < POT_W'(BAND_HIGH));
        end
    end

`ifndef SYNTHESIS
    // Input is refused only while the output item is stalled.
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input refused without an output stall");

    // An accepted item shows up at the output after the fixed latency when
    // nothing stalls in between.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 en [* LAT-1] |=> out_valid)
        else $error("latency chain broken");

    // A delivered potential never exceeds three full terms.
    a_pot_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.potential <= POT_W'(POT_MAX)))
        else $error("potential out of range");

    // A stalled output item holds while the pipeline stands.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("stalled output item changed");
`endif

endmodule

// File: sv/mbt_sqrt.sv
// ============================================================================
// mbt_sqrt
// Pipelined integer square root, one root bit per stage.
// ============================================================================
module mbt_sqrt
    import mbt_pkg::*;
#(
    parameter int K = 28
)
(
    input  logic           clk,
    input  logic           en,
    input  logic [2*K-1:0] rad,
    output logic [K-1:0]   root,
    output logic [K+1:0]   rem
);

    logic [K+1:0]   rem_reg  [K];
    logic [K-1:0]   root_reg [K];
    logic [2*K-1:0] rad_reg  [K];

    for (genvar s = 0; s < K; s++) begin : g_stage
        localparam int J = K - 1 - s;
        logic [K+1:0]   rem_in;
        logic [K-1:0]   root_in;
        logic [2*K-1:0] rad_in;
        logic [K+3:0]   rem_sh;
        logic [K+3:0]   trial;
        logic [K+1:0]   rem_next;
        logic [K-1:0]   root_next;

        if (s == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
        end
        else begin : g_next
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign rad_in  = rad_reg[s-1];
        end

        assign rem_sh = {rem_in, rad_in[2*J+1 -: 2]};
        assign trial  = {2'b00, root_in, 2'b01};

        always_comb
        begin
            if (rem_sh >= trial)
            begin
                rem_next  = (K+2)'(rem_sh - trial);
                root_next = {root_in[K-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[K+1:0];
                root_next = {root_in[K-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
                rad_reg[s]  <= rad_in;
            end
        end
    end

    assign root = root_reg[K-1];
    assign rem  = rem_reg[K-1];

endmodule

// File: sv/mbt_div.sv
// ============================================================================
// mbt_div
// Pipelined restoring divider with a short quotient, one bit per stage.
// ============================================================================
module mbt_div
    import mbt_pkg::*;
#(
    parameter int NUM_W = 36
)
(
    input  logic              clk,
    input  logic              en,
    input  logic [NUM_W-1:0]  num,
    input  logic [NUM_W-1:0]  den,
    output logic [TERM_W-1:0] quo
);

    localparam int W = NUM_W + TERM_W;

    logic [NUM_W-1:0]  rem_reg [TERM_W];
    logic [NUM_W-1:0]  den_reg [TERM_W];
    logic [TERM_W-1:0] quo_reg [TERM_W];

    for (genvar s = 0; s < TERM_W; s++) begin : g_stage
        localparam int I = TERM_W - 1 - s;
        logic [NUM_W-1:0]  rem_in;
        logic [NUM_W-1:0]  den_in;
        logic [TERM_W-1:0] quo_in;
        logic [W-1:0]      den_sh;
        logic              take;

        if (s == 0) begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else begin : g_next
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign quo_in = quo_reg[s-1];
        end

        assign den_sh = W'(den_in) << I;
        assign take   = W'(rem_in) >= den_sh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= take ? (rem_in - den_sh[NUM_W-1:0]) : rem_in;
                den_reg[s] <= den_in;
                quo_reg[s] <= {quo_in[TERM_W-2:0], take};
            end
        end
    end

    assign quo = quo_reg[TERM_W-1];

endmodule

// File: sv/mbt_center.sv
// ============================================================================
// mbt_center
// Potential term of one center: distance, rounded root, rounded quotient.
// ============================================================================
module mbt_center
    import mbt_pkg::*;
#(
    parameter int M_W = 26
)
(
    input  logic                       clk,
    input  logic                       en,
    input  logic [M_W-1:0]             mx,
    input  logic [M_W-1:0]             my,
    input  logic signed [CENTER_W-1:0] cx,
    input  logic signed [CENTER_W-1:0] cy,
    output logic [TERM_W-1:0]          term
);

    localparam int DIFF_W = M_W + 1;
    localparam int K      = M_W + 2;
    localparam int NUM_W  = K + 8;

    logic signed [M_W+1:0] diff_x, diff_y;
    logic [DIFF_W-1:0]     dx_reg, dy_reg;
    logic [2*DIFF_W-1:0]   sqx_reg, sqy_reg;
    logic [2*K-1:0]        dist2_reg;
    logic [K-1:0]          root;
    logic [K+1:0]          rem;
    logic [K-1:0]          d_reg;
    logic [NUM_W-1:0]      num_reg, den_reg;

    assign diff_x = $signed({2'b00, mx}) - (M_W+2)'(cx);
    assign diff_y = $signed({2'b00, my}) - (M_W+2)'(cy);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg    <= diff_x[M_W+1] ? DIFF_W'(-diff_x) : DIFF_W'(diff_x);
            dy_reg    <= diff_y[M_W+1] ? DIFF_W'(-diff_y) : DIFF_W'(diff_y);
            sqx_reg   <= dx_reg * dx_reg;
            sqy_reg   <= dy_reg * dy_reg;
            dist2_reg <= (2*K)'(sqx_reg) + (2*K)'(sqy_reg);
        end
    end

    mbt_sqrt #(.K(K)) u_sqrt
    (
        .clk  (clk),
        .en   (en),
        .rad  (dist2_reg),
        .root (root),
        .rem  (rem)
    );

    // Round the root up when the leftover exceeds the root.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg   <= root + K'(rem > (K+2)'(root));
            // Denominator is even, so its half is exact: 2^13 + 50*d.
            num_reg <= NUM_W'(TERM_NUMER + ONE_Q14 / 2)
                     + NUM_W'(d_reg) * NUM_W'(TERM_SCALE / 2);
            den_reg <= NUM_W'(ONE_Q14) + NUM_W'(d_reg) * NUM_W'(TERM_SCALE);
        end
    end

    mbt_div #(.NUM_W(NUM_W)) u_div
    (
        .clk (clk),
        .en  (en),
        .num (num_reg),
        .den (den_reg),
        .quo (term)
    );

endmodule

// File: test/metaball_band_test_test.sv
// ============================================================================
// metaball_band_test_test
// Self-checking bench for the metaball band test block.
// ============================================================================
// Sample items go in over a valid/ready channel. Each accepted item is run
// through a fixed-point model of the potential, and the result is queued. Every
// result item that leaves the block is checked against the oldest queued one.
// The bench starts with a short table of directed samples. After that come
// random phases, most under a new set of centers and scales. Each phase aims
// half its samples close to a center so that the narrow inside band is reached.
// ============================================================================
module metaball_band_test_test;
    import mbt_pkg::*;

    localparam int LATENCY = 51;
    localparam int SETTLE  = LATENCY + 20;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    point_t            in_data;
    logic              out_valid;
    logic              out_ready;
    result_t           out_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Shadow copy of the register file, used by the potential model.
    logic signed [CENTER_W-1:0] ctr_x [3];
    logic signed [CENTER_W-1:0] ctr_y [3];
    logic [SCALE_W-1:0]         scale_x;
    logic [SCALE_W-1:0]         scale_y;

    result_t pending_results [$];
    int      fail_count;
    bit      quiet;       // no idling on either side in the last part of the run
    bit      hold_req;    // ask the receiver for one long stall

    typedef struct {
        logic [15:0] sx;
        logic [15:0] sy;
        bit          typed;
        result_t     res;
    } dir_row_t;

    metaball_band_test uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop well past the slowest correct run.
    initial
    begin
        #60000000;
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Potential model
    // ------------------------------------------------------------------

    // Integer square root, rounded to nearest (ties go up).
    function automatic longint unsigned sqrt_nearest(longint unsigned n);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned b;
        rem  = n;
        root = 0;
        b    = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (rem >= root + b)
            begin
                rem  = rem - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        if (rem > root)
            root++;
        return root;
    endfunction

    // One center's share: 100 / (1 + 100 * d), in Q9.8.
    function automatic longint unsigned center_share(longint mx, longint my,
                                                     logic signed [15:0] cx,
                                                     logic signed [15:0] cy);
        longint          dx;
        longint          dy;
        longint unsigned d;
        longint unsigned den;
        dx  = mx - longint'(cx);
        dy  = my - longint'(cy);
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        d   = sqrt_nearest(longint'(dx * dx) + longint'(dy * dy));
        den = ONE_Q14 + TERM_SCALE * d;
        return (TERM_NUMER + den / 2) / den;
    endfunction

    // Map the sample into normalized Q.14 and sum the three shares.
    function automatic result_t potential_of(point_t s);
        longint          mx;
        longint          my;
        longint unsigned pot;
        result_t         r;
        mx  = longint'((64'(s.sample_x) * 64'(scale_x) + 64'd8192) >> 14);
        my  = longint'((64'(s.sample_y) * 64'(scale_y) + 64'd8192) >> 14);
        pot = 0;
        for (int k = 0; k < 3; k++)
            pot += center_share(mx, my, ctr_x[k], ctr_y[k]);
        r.inside_res = (pot > BAND_LOW && pot < BAND_HIGH);
        r.potential  = pot[POT_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result item with nothing expected: inside_res %0d potential %0d",
                       out_data.inside_res, out_data.potential);
                fail_count++;
            end
            else
            begin
                result_t want;
                want = pending_results.pop_front();
                if (out_data.inside_res !== want.inside_res)
                begin
                    $error("inside_res: expected %0d, got %0d",
                           want.inside_res, out_data.inside_res);
                    fail_count++;
                end
                if (out_data.potential !== want.potential)
                begin
                    $error("potential: expected %0d, got %0d",
                           want.potential, out_data.potential);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, one long hold on request
    // ------------------------------------------------------------------
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                // Hold off long enough for the pipeline to fill and push back.
                hold_req  = 1'b0;
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
                // Run some stretches with no stall at all.
                if ($urandom_range(0, 7) == 0)
                    repeat ($urandom_range(10, 40)) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender and register port
    // ------------------------------------------------------------------

    // Offer one item; called at a clock edge, returns at the accepting edge.
    task automatic send_sample(point_t s);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(potential_of(s));
    endtask

    // Drain the pipeline, then write one register with the given value.
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CENTER0_X: ctr_x[0] = value[15:0];
            REG_CENTER0_Y: ctr_y[0] = value[15:0];
            REG_CENTER1_X: ctr_x[1] = value[15:0];
            REG_CENTER1_Y: ctr_y[1] = value[15:0];
            REG_CENTER2_X: ctr_x[2] = value[15:0];
            REG_CENTER2_Y: ctr_y[2] = value[15:0];
            REG_X_SCALE:   scale_x  = value[23:0];
            REG_Y_SCALE:   scale_y  = value[23:0];
        endcase
    endtask

    // Load all eight registers; upper data bits carry junk to check masking.
    task automatic load_setting(int cx0, int cy0, int cx1, int cy1,
                                int cx2, int cy2, int sx, int sy);
        write_reg(REG_CENTER0_X, {16'($urandom_range(0, 65535)), cx0[15:0]});
        write_reg(REG_CENTER0_Y, {16'($urandom_range(0, 65535)), cy0[15:0]});
        write_reg(REG_CENTER1_X, {16'($urandom_range(0, 65535)), cx1[15:0]});
        write_reg(REG_CENTER1_Y, {16'($urandom_range(0, 65535)), cy1[15:0]});
        write_reg(REG_CENTER2_X, {16'($urandom_range(0, 65535)), cx2[15:0]});
        write_reg(REG_CENTER2_Y, {16'($urandom_range(0, 65535)), cy2[15:0]});
        write_reg(REG_X_SCALE,   {8'($urandom_range(0, 255)), sx[23:0]});
        write_reg(REG_Y_SCALE,   {8'($urandom_range(0, 255)), sy[23:0]});
        @(posedge clk);
    endtask

    // Pixel coordinate that maps near normalized position m under scale.
    function automatic logic [15:0] aim_at(longint m, logic [23:0] scale);
        longint p;
        if (scale == 0 || m <= 0)
            return 16'($urandom_range(0, 65535));
        p = (m << 14) / longint'(scale);
        if (p > 65535)
            p = 65535;
        return p[15:0];
    endfunction

    // Random items: half fully random, half aimed close to some center.
    task automatic random_phase(int count);
        point_t s;
        int     k;
        int     spread;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                s.sample_x = 16'($urandom_range(0, 65535));
                s.sample_y = 16'($urandom_range(0, 65535));
            end
            else
            begin
                k      = $urandom_range(0, 2);
                spread = ($urandom_range(0, 1) == 0) ? 400 : 4000;
                s.sample_x = aim_at(longint'(ctr_x[k]) + $urandom_range(0, 2 * spread)
                                    - spread, scale_x);
                s.sample_y = aim_at(longint'(ctr_y[k]) + $urandom_range(0, 2 * spread)
                                    - spread, scale_y);
            end
            send_sample(s);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        dir_row_t rows [$];
        dir_row_t row;
        point_t   s;
        result_t  zero_res;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        fail_count = 0;
        quiet     = 1'b0;
        hold_req  = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            ctr_x[k] = 16'sd8192;
            ctr_y[k] = 16'sd8192;
        end
        scale_x = 24'd16384;
        scale_y = 24'd16384;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under reset settings (scale 1/1024, all centers at 0.5).
        zero_res = '0;
        rows.push_back('{16'd0,     16'd0,     1'b1, '{1'b0, 17'd1071}});  // far corner
        rows.push_back('{16'd8192,  16'd8192,  1'b1, '{1'b0, 17'd76800}}); // on the centers
        rows.push_back('{16'd65535, 16'd65535, 1'b0, zero_res});
        rows.push_back('{16'd0,     16'd65535, 1'b0, zero_res});
        rows.push_back('{16'd65535, 16'd0,     1'b0, zero_res});
        rows.push_back('{16'd8456,  16'd8192,  1'b0, zero_res});            // near the band
        rows.push_back('{16'd8192,  16'd7900,  1'b0, zero_res});
        rows.push_back('{16'd8380,  16'd8380,  1'b0, zero_res});
        rows.push_back('{16'd1,     16'd1,     1'b0, zero_res});
        rows.push_back('{16'd32768, 16'd32768, 1'b0, zero_res});
        rows.push_back('{16'd8191,  16'd8193,  1'b0, zero_res});
        rows.push_back('{16'hAAAA,  16'h5555,  1'b0, zero_res});
        rows.push_back('{16'h5555,  16'hAAAA,  1'b0, zero_res});
        foreach (rows[i])
        begin
            row = rows[i];
            s.sample_x = row.sx;
            s.sample_y = row.sy;
            send_sample(s);
            if (row.typed)
            begin
                // Replace the model's entry with the hand-worked value.
                void'(pending_results.pop_back());
                pending_results.push_back(row.res);
            end
        end

        // Dense clustering near the reset centers; reach the inside band.
        random_phase(200);
        hold_req = 1'b1;     // long receiver hold while items keep coming
        random_phase(200);

        // Extreme centers, smallest stated scale.
        load_setting(-32768, 32767, 32767, -32768, -32768, -32768, 4096, 4096);
        random_phase(200);

        // Largest stated scale, random centers.
        load_setting($urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 65535),
                     8388608, 8388608);
        random_phase(200);

        // Scales outside the stated range: zero and all ones.
        load_setting(0, 0, 32767, 32767, -1, 1, 0, 24'hFFFFFF);
        random_phase(150);
        load_setting(100, -100, 16384, 8000, 4000, 12000, 24'hFFFFFF, 0);
        random_phase(150);

        // Everything random.
        load_setting($urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(4096, 8388608), $urandom_range(4096, 8388608));
        random_phase(350);

        // Close centers at scale 1/1024; last part runs with no idling.
        load_setting(8192, 8192, 8400, 8192, 8192, 8450, 16384, 16384);
        random_phase(100);
        quiet = 1'b1;
        random_phase(300);

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
